// ===== rtl/nmea_gga_position_parser_top_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef NMEA_GGA_POSITION_PARSER_TOP_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_TOP_MACROS_SVH

// condition and consequence in the same cycle
`define NGP_ASSERT_NOW(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define NGP_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ngp_pkg.sv =====
// constants, types and helper functions of the gga position parser
package ngp_pkg;

	// number format
	localparam int FRAC_DIGITS     = 5;
	localparam int MAX_INT_DIGITS  = 5;
	localparam int MIN_INT_DIGITS  = 2;
	localparam int COORD_W         = 35;

	// characters
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_POINT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_W      = 8'h57;

	// header matcher
	localparam int HDR_LEN = 6;
	localparam int HDR_W   = $clog2(HDR_LEN + 1);

	// field numbers, counted in commas from line start
	localparam int COMMA_W = 3;
	localparam logic [COMMA_W-1:0] FIELD_LAT      = 3'd2;
	localparam logic [COMMA_W-1:0] FIELD_LAT_HEMI = 3'd3;
	localparam logic [COMMA_W-1:0] FIELD_LON      = 3'd4;
	localparam logic [COMMA_W-1:0] FIELD_LON_HEMI = 3'd5;
	localparam logic [COMMA_W-1:0] COMMA_MAX      = 3'd7;

	// accumulator widths
	localparam int ICNT_W = $clog2(MAX_INT_DIGITS + 1);
	localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
	localparam int DEG_W  = $clog2(10 ** (MAX_INT_DIGITS - 2));
	localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);

	// minutes * 1e7 / (60 * 10^FRAC_DIGITS) = minutes * MUL_C / DIV_C
	localparam int MUL_C = (FRAC_DIGITS <= 6) ? 10 ** (6 - FRAC_DIGITS) : 1;
	localparam int DIV_C = (FRAC_DIGITS <= 6) ? 6 : 60;
	localparam int X_W   = $clog2(100 * (10 ** FRAC_DIGITS) * MUL_C);

	// reciprocal of DIV_C, exact for every value below 2^X_W
	localparam int REC_K = X_W + $clog2(DIV_C) + 1;
	localparam longint unsigned RECIP = ((64'd1 << REC_K) + DIV_C - 1) / DIV_C;
	localparam int REC_W = $clog2(RECIP + 1);
	localparam int PROD_W = X_W + REC_W;

	localparam logic [X_W-1:0]     MIN2_SCALE = X_W'((10 ** FRAC_DIGITS) * MUL_C);
	localparam logic [X_W-1:0]     FRAC_SCALE = X_W'(MUL_C);
	localparam logic [PROD_W-1:0]  RECIP_V    = PROD_W'(RECIP);
	localparam logic [COORD_W-1:0] DEG_SCALE  = COORD_W'(10000000);

	// hemisphere field contents
	typedef enum logic [1:0] {
		HEMI_EMPTY,
		HEMI_NEG,
		HEMI_OTHER
	} hemi_t;

	// finished coordinate before scaling
	typedef struct packed {
		logic [DEG_W-1:0] deg;
		logic [X_W-1:0]   x;
		logic             neg;
	} raw_coord_t;

	// coordinate after the multipliers
	typedef struct packed {
		logic [COORD_W-1:0] deg_sc;
		logic [PROD_W-1:0]  prod;
		logic               neg;
	} prod_coord_t;

	// expected header character at a match position
	function automatic logic [7:0] hdr_char(logic [HDR_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h24;
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h50;
			3'd3:    c = 8'h47;
			3'd4:    c = 8'h47;
			3'd5:    c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// place value of the fraction digit at position n
	function automatic logic [FRAC_W-1:0] frac_weight(logic [FCNT_W-1:0] n);
		logic [FRAC_W-1:0] w;
		w = '0;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (n == FCNT_W'(i)) begin
				w = FRAC_W'(10 ** (FRAC_DIGITS - 1 - i));
			end
		end
		return w;
	endfunction

endpackage

// ===== rtl/nmea_gga_position_parser_top.sv =====
// gga sentence parser: byte parsing, coordinate scaling pipeline and result register
//
//  channel | signals                                     | carries
//  --------+---------------------------------------------+-------------------------------
//  byte    | byte_valid, byte_ready, rx_byte             | one character of nmea text
//  fix     | fix_valid, fix_ready, latitude_e7,          | one position per gga line
//          | longitude_e7, status                        |
//
// one byte per cycle while byte_ready is high; parse state updates in the cycle the byte is taken
// a position passes three registered stages after the edge that takes its newline:
// stage 1 holds the line values, stage 2 multiplies, stage 3 sums and signs
// reset clears the parser and the stage valid bits; no clearing pass
// a stalled fix channel holds the result; bytes keep flowing until all three
// result stages are full
`include "nmea_gga_position_parser_top_macros.svh"

module nmea_gga_position_parser_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           fix_valid,
	input  logic                           fix_ready,
	output logic signed [ngp_pkg::COORD_W-1:0] latitude_e7,
	output logic signed [ngp_pkg::COORD_W-1:0] longitude_e7,
	output logic                           status
);
	import ngp_pkg::*;

	// parser state
	logic [HDR_W-1:0]   header_progress_q;
	logic               header_seen_q;
	logic [COMMA_W-1:0] comma_q;
	logic [DEG_W-1:0]   deg_acc_q;
	logic [3:0]         dig1_q;
	logic [3:0]         dig0_q;
	logic [ICNT_W-1:0]  int_cnt_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [FCNT_W-1:0]  frac_cnt_q;
	logic               point_q;
	logic               field_bad_q;
	hemi_t              hemi_q;
	raw_coord_t         lat_q;
	raw_coord_t         lon_q;
	logic               coord_error_q;

	// next values
	logic [HDR_W-1:0]   header_progress_d;
	logic               header_seen_d;
	logic [COMMA_W-1:0] comma_d;
	logic [DEG_W-1:0]   deg_acc_d;
	logic [3:0]         dig1_d;
	logic [3:0]         dig0_d;
	logic [ICNT_W-1:0]  int_cnt_d;
	logic [FRAC_W-1:0]  frac_d;
	logic [FCNT_W-1:0]  frac_cnt_d;
	logic               point_d;
	logic               field_bad_d;
	hemi_t              hemi_d;
	raw_coord_t         lat_d;
	raw_coord_t         lon_d;
	logic               coord_error_d;
	raw_coord_t         lat_fin;
	raw_coord_t         lon_fin;
	logic               err_fin;

	logic               is_digit;
	logic               fin_bad;
	logic [6:0]         min2;
	raw_coord_t         fin_coord;
	logic [HDR_W-1:0]   hdr_inc;
	logic               byte_acc;
	logic               push;

	// result pipeline
	logic               v_s1, v_s2, v_s3;
	logic               rdy_s1, rdy_s2, rdy_s3;
	raw_coord_t         lat_s1, lon_s1;
	logic               err_s1, err_s2;
	prod_coord_t        lat_s2, lon_s2;
	logic [COORD_W-1:0] lat_mag, lon_mag;

	// handshake and stage readiness
	assign rdy_s3     = !v_s3 || fix_ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign byte_ready = rdy_s1;
	assign byte_acc   = byte_valid && byte_ready;
	assign fix_valid  = v_s3;

	// value of the open coordinate field when it closes
	assign min2     = 7'(dig1_q) * 7'd10 + 7'(dig0_q);
	assign fin_bad  = field_bad_q || (int_cnt_q < ICNT_W'(MIN_INT_DIGITS));
	assign fin_coord.deg = fin_bad ? '0 : deg_acc_q;
	assign fin_coord.x   = fin_bad ? '0 :
		X_W'(min2) * MIN2_SCALE + X_W'(frac_q) * FRAC_SCALE;
	assign fin_coord.neg = 1'b0;

	assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign hdr_inc  = header_progress_q + HDR_W'(1);

	// parser next state
	always_comb begin
		header_progress_d = header_progress_q;
		header_seen_d     = header_seen_q;
		comma_d           = comma_q;
		deg_acc_d         = deg_acc_q;
		dig1_d            = dig1_q;
		dig0_d            = dig0_q;
		int_cnt_d         = int_cnt_q;
		frac_d            = frac_q;
		frac_cnt_d        = frac_cnt_q;
		point_d           = point_q;
		field_bad_d       = field_bad_q;
		hemi_d            = hemi_q;
		lat_d             = lat_q;
		lon_d             = lon_q;
		coord_error_d     = coord_error_q;
		push              = 1'b0;

		// close the open field on a comma or newline
		if ((rx_byte == CHAR_LF) || (rx_byte == CHAR_COMMA)) begin
			case (comma_q)
				FIELD_LAT: begin
					lat_d.deg = fin_coord.deg;
					lat_d.x   = fin_coord.x;
					if (fin_bad) begin
						coord_error_d = 1'b1;
					end
				end
				FIELD_LAT_HEMI: lat_d.neg = (hemi_q == HEMI_NEG);
				FIELD_LON: begin
					lon_d.deg = fin_coord.deg;
					lon_d.x   = fin_coord.x;
					if (fin_bad) begin
						coord_error_d = 1'b1;
					end
				end
				FIELD_LON_HEMI: lon_d.neg = (hemi_q == HEMI_NEG);
				default: ;
			endcase
		end

		// line values as they stand at a newline, before the restart
		lat_fin = lat_d;
		lon_fin = lon_d;
		err_fin = coord_error_d;

		if (rx_byte == CHAR_LF) begin
			// end of line: emit for a gga line with enough fields, then restart
			push              = byte_acc && header_seen_q && (comma_q >= FIELD_LON_HEMI);
			header_progress_d = '0;
			header_seen_d     = 1'b0;
			comma_d           = '0;
			coord_error_d     = 1'b0;
			lat_d.neg         = 1'b0;
			lon_d.neg         = 1'b0;
		end else begin
			// header match
			if ((header_progress_q < HDR_W'(HDR_LEN)) && (rx_byte == hdr_char(header_progress_q))) begin
				header_progress_d = hdr_inc;
			end else begin
				header_progress_d = (rx_byte == CHAR_DOLLAR) ? HDR_W'(1) : '0;
			end
			if (header_progress_d >= HDR_W'(HDR_LEN)) begin
				header_seen_d     = 1'b1;
				header_progress_d = '0;
			end

			if (rx_byte == CHAR_COMMA) begin
				if (comma_q < COMMA_MAX) begin
					comma_d = comma_q + COMMA_W'(1);
				end
			end else if ((comma_q == FIELD_LAT) || (comma_q == FIELD_LON)) begin
				// coordinate characters
				if (is_digit) begin
					if (!point_q) begin
						if (int_cnt_q < ICNT_W'(MAX_INT_DIGITS)) begin
							deg_acc_d = deg_acc_q * DEG_W'(10) + DEG_W'(dig1_q);
							dig1_d    = dig0_q;
							dig0_d    = rx_byte[3:0];
							int_cnt_d = int_cnt_q + ICNT_W'(1);
						end else begin
							field_bad_d = 1'b1;
						end
					end else if (frac_cnt_q < FCNT_W'(FRAC_DIGITS)) begin
						frac_d     = frac_q + FRAC_W'(FRAC_W'(rx_byte[3:0]) *
							frac_weight(frac_cnt_q));
						frac_cnt_d = frac_cnt_q + FCNT_W'(1);
					end
				end else if (rx_byte == CHAR_POINT) begin
					if (point_q) begin
						field_bad_d = 1'b1;
					end
					point_d = 1'b1;
				end else begin
					field_bad_d = 1'b1;
				end
			end else if ((comma_q == FIELD_LAT_HEMI) || (comma_q == FIELD_LON_HEMI)) begin
				// hemisphere characters
				if ((hemi_q == HEMI_EMPTY) && ((rx_byte == CHAR_S) || (rx_byte == CHAR_W))) begin
					hemi_d = HEMI_NEG;
				end else begin
					hemi_d = HEMI_OTHER;
				end
			end
		end

		// new field or new line starts empty
		if ((rx_byte == CHAR_LF) || (rx_byte == CHAR_COMMA)) begin
			deg_acc_d   = '0;
			dig1_d      = '0;
			dig0_d      = '0;
			int_cnt_d   = '0;
			frac_d      = '0;
			frac_cnt_d  = '0;
			point_d     = 1'b0;
			field_bad_d = 1'b0;
			hemi_d      = HEMI_EMPTY;
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_progress_q <= '0;
			header_seen_q     <= 1'b0;
			comma_q           <= '0;
			deg_acc_q         <= '0;
			dig1_q            <= '0;
			dig0_q            <= '0;
			int_cnt_q         <= '0;
			frac_q            <= '0;
			frac_cnt_q        <= '0;
			point_q           <= 1'b0;
			field_bad_q       <= 1'b0;
			hemi_q            <= HEMI_EMPTY;
			lat_q             <= '0;
			lon_q             <= '0;
			coord_error_q     <= 1'b0;
		end else if (byte_acc) begin
			header_progress_q <= header_progress_d;
			header_seen_q     <= header_seen_d;
			comma_q           <= comma_d;
			deg_acc_q         <= deg_acc_d;
			dig1_q            <= dig1_d;
			dig0_q            <= dig0_d;
			int_cnt_q         <= int_cnt_d;
			frac_q            <= frac_d;
			frac_cnt_q        <= frac_cnt_d;
			point_q           <= point_d;
			field_bad_q       <= field_bad_d;
			hemi_q            <= hemi_d;
			lat_q             <= lat_d;
			lon_q             <= lon_d;
			coord_error_q     <= coord_error_d;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= push;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: finished coordinates of the line
	always_ff @(posedge clk) begin
		if (push) begin
			lat_s1 <= lat_fin;
			lon_s1 <= lon_fin;
			err_s1 <= err_fin;
		end
	end

	// stage 2: degree scaling and minutes reciprocal multiply
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			lat_s2.deg_sc <= COORD_W'(lat_s1.deg) * DEG_SCALE;
			lat_s2.prod   <= PROD_W'(lat_s1.x) * RECIP_V;
			lat_s2.neg    <= lat_s1.neg;
			lon_s2.deg_sc <= COORD_W'(lon_s1.deg) * DEG_SCALE;
			lon_s2.prod   <= PROD_W'(lon_s1.x) * RECIP_V;
			lon_s2.neg    <= lon_s1.neg;
			err_s2        <= err_s1;
		end
	end

	// stage 3: sum, sign and result register
	assign lat_mag = lat_s2.deg_sc + COORD_W'(lat_s2.prod >> REC_K);
	assign lon_mag = lon_s2.deg_sc + COORD_W'(lon_s2.prod >> REC_K);

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			latitude_e7  <= lat_s2.neg ? -lat_mag : lat_mag;
			longitude_e7 <= lon_s2.neg ? -lon_mag : lon_mag;
			status       <= err_s2;
		end
	end

	// checks
	`NGP_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !byte_ready, v_s1 && v_s2 && v_s3 && !fix_ready, "byte channel stalled with a free result stage")
	`NGP_ASSERT_NEXT(a_newline_clears, clk, arst_n, byte_valid && byte_ready && rx_byte == CHAR_LF, comma_q == '0 && !header_seen_q && !coord_error_q, "parser state not cleared after newline")
	`NGP_ASSERT_NOW(a_error_after_coord, clk, arst_n, coord_error_q, comma_q > FIELD_LAT, "coordinate error flagged before a coordinate field closed")

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the gga position parser: byte stream in, positions checked
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ngp_pkg::*;

	localparam int LIMIT = 500000;
	localparam logic [8*HDR_LEN-1:0] GGA_TAG = "$GPGGA";
	localparam longint unsigned FSCALE = 10 ** FRAC_DIGITS;
	localparam longint unsigned E7 = 64'd10000000;

	typedef struct packed {
		logic signed [COORD_W-1:0] lat;
		logic signed [COORD_W-1:0] lon;
		logic                      st;
	} fix_t;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_ready;
	logic [7:0] rx_byte;
	logic fix_valid;
	logic fix_ready;
	logic signed [COORD_W-1:0] latitude_e7;
	logic signed [COORD_W-1:0] longitude_e7;
	logic status;

	nmea_gga_position_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.rx_byte(rx_byte),
		.fix_valid(fix_valid),
		.fix_ready(fix_ready),
		.latitude_e7(latitude_e7),
		.longitude_e7(longitude_e7),
		.status(status)
	);

	// shadow parser state
	logic [HDR_W-1:0]   tag_pos;
	bit                 tag_found;
	logic [COMMA_W-1:0] field_no;
	longint unsigned    int_acc;
	int                 int_cnt;
	longint unsigned    frac_acc;
	int                 frac_cnt;
	bit                 dot_seen;
	bit                 field_broken;
	hemi_t              hemi;
	logic [63:0]        lat_acc;
	logic [63:0]        lon_acc;
	bit                 coord_broken;

	fix_t fix_q[$];
	bit   idle_on = 1'b1;
	int   byte_cnt = 0;
	int   fix_pred = 0;
	int   fix_seen = 0;
	int   err_cnt = 0;
	int   cycle_cnt = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_cnt < 40)
			$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_cnt++;
	endtask

	function automatic void clear_field_state();
		int_acc = 0;
		int_cnt = 0;
		frac_acc = 0;
		frac_cnt = 0;
		dot_seen = 1'b0;
		field_broken = 1'b0;
		hemi = HEMI_EMPTY;
	endfunction

	function automatic void clear_line_state();
		tag_pos = '0;
		tag_found = 1'b0;
		field_no = '0;
		clear_field_state();
		lat_acc = '0;
		lon_acc = '0;
		coord_broken = 1'b0;
	endfunction

	// degrees * 1e7 from the collected ddmm.mmmmm digits
	function automatic logic [63:0] coord_degrees_e7();
		longint unsigned fr;
		longint unsigned deg;
		longint unsigned mins;
		fr = frac_acc;
		if (field_broken || int_cnt < MIN_INT_DIGITS) begin
			coord_broken = 1'b1;
			return 64'd0;
		end
		for (int n = frac_cnt; n < FRAC_DIGITS; n++)
			fr = fr * 10;
		deg = int_acc / 100;
		mins = (int_acc % 100) * FSCALE + fr;
		return deg * E7 + (mins * E7) / (64'd60 * FSCALE);
	endfunction

	function automatic void close_field();
		case (field_no)
			FIELD_LAT: lat_acc = coord_degrees_e7();
			FIELD_LON: lon_acc = coord_degrees_e7();
			FIELD_LAT_HEMI: if (hemi == HEMI_NEG) lat_acc = 64'd0 - lat_acc;
			FIELD_LON_HEMI: if (hemi == HEMI_NEG) lon_acc = 64'd0 - lon_acc;
			default: ;
		endcase
	endfunction

	function automatic void field_byte(input logic [7:0] c);
		if (field_no == FIELD_LAT || field_no == FIELD_LON) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				if (!dot_seen) begin
					if (int_cnt < MAX_INT_DIGITS) begin
						int_acc = int_acc * 10 + (c - CHAR_ZERO);
						int_cnt++;
					end else begin
						field_broken = 1'b1;
					end
				end else if (frac_cnt < FRAC_DIGITS) begin
					frac_acc = frac_acc * 10 + (c - CHAR_ZERO);
					frac_cnt++;
				end
			end else if (c == CHAR_POINT) begin
				if (dot_seen)
					field_broken = 1'b1;
				dot_seen = 1'b1;
			end else begin
				field_broken = 1'b1;
			end
		end else if (field_no == FIELD_LAT_HEMI || field_no == FIELD_LON_HEMI) begin
			if (hemi == HEMI_EMPTY && (c == CHAR_S || c == CHAR_W))
				hemi = HEMI_NEG;
			else
				hemi = HEMI_OTHER;
		end
	endfunction

	// advance the shadow parser by one accepted byte
	function automatic void parse_byte(input logic [7:0] c);
		fix_t f;
		if (c == CHAR_LF) begin
			if (field_no >= FIELD_LAT && field_no <= FIELD_LON_HEMI)
				close_field();
			if (tag_found && field_no >= FIELD_LON_HEMI) begin
				f.lat = lat_acc[COORD_W-1:0];
				f.lon = lon_acc[COORD_W-1:0];
				f.st = coord_broken;
				fix_q.insert(fix_q.size(), f);
				fix_pred++;
			end
			clear_line_state();
			return;
		end
		if (tag_pos < HDR_LEN && c == GGA_TAG[8*(HDR_LEN-1-int'(tag_pos)) +: 8])
			tag_pos = tag_pos + 1'b1;
		else
			tag_pos = (c == CHAR_DOLLAR) ? HDR_W'(1) : HDR_W'(0);
		if (tag_pos >= HDR_LEN) begin
			tag_found = 1'b1;
			tag_pos = '0;
		end
		if (c == CHAR_COMMA) begin
			if (field_no >= FIELD_LAT && field_no <= FIELD_LON_HEMI)
				close_field();
			if (field_no < COMMA_MAX)
				field_no = field_no + 1'b1;
			clear_field_state();
		end else begin
			field_byte(c);
		end
	endfunction

	// watch both channels: predict on byte requests, check on fix requests
	always @(posedge clk) begin
		fix_t want;
		if (arst_n) begin
			if (fix_valid === 1'b1 && fix_ready === 1'b1) begin
				fix_seen++;
				if (fix_q.size() == 0) begin
					report_mismatch("unexpected position", latitude_e7, 0);
				end else begin
					want = fix_q.pop_front();
					if (latitude_e7 !== want.lat)
						report_mismatch("latitude_e7", latitude_e7, $signed(want.lat));
					if (longitude_e7 !== want.lon)
						report_mismatch("longitude_e7", longitude_e7, $signed(want.lon));
					if (status !== want.st)
						report_mismatch("status", longint'(status), longint'(want.st));
				end
			end
			if (byte_valid === 1'b1 && byte_ready === 1'b1) begin
				byte_cnt++;
				parse_byte(rx_byte);
			end
		end
	end

	// fix channel backpressure in random bursts
	initial begin
		int stall;
		stall = 0;
		fix_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				fix_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				fix_ready <= 1'b0;
			end else begin
				fix_ready <= 1'b1;
			end
		end
	end

	// one byte request, with an optional idle burst in front
	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte <= c;
		do @(posedge clk); while (byte_ready !== 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// stop sending and let every expected position come out
	task automatic wait_drained();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (fix_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic string digits(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	// printable character that is neither digit, point nor comma
	function automatic string junk_char();
		int ch;
		do ch = $urandom_range(33, 126);
		while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_POINT || ch == CHAR_COMMA);
		return $sformatf("%c", ch);
	endfunction

	function automatic string good_coord();
		string s;
		s = digits($urandom_range(MIN_INT_DIGITS, MAX_INT_DIGITS));
		if ($urandom_range(0, 6) != 0)
			s = {s, ".", digits($urandom_range(0, FRAC_DIGITS + 2))};
		return s;
	endfunction

	function automatic string bad_coord();
		string s;
		case ($urandom_range(0, 6))
			0: s = "";
			1: s = {digits(1), ".", digits(3)};
			2: s = {digits($urandom_range(MAX_INT_DIGITS + 1, 8)), ".", digits(2)};
			3: s = {digits(4), ".", digits(2), ".", digits(1)};
			4: s = {digits(2), junk_char(), digits(2)};
			5: s = {".", digits(3)};
			default: s = {digits(3), ".", junk_char()};
		endcase
		return s;
	endfunction

	function automatic string hemi_text(input bit clean);
		string s;
		if (clean) begin
			case ($urandom_range(0, 3))
				0: s = "N";
				1: s = "S";
				2: s = "E";
				default: s = "W";
			endcase
		end else begin
			case ($urandom_range(0, 7))
				0: s = "N";
				1: s = "S";
				2: s = "W";
				3: s = "";
				4: s = "SS";
				5: s = "s";
				6: s = "WE";
				default: s = junk_char();
			endcase
		end
		return s;
	endfunction

	// one gga sentence; unclean ones carry malformed fields and odd prefixes
	function automatic string gga_line(input bit clean);
		string pre, lat, lon, tail, eol;
		pre = "";
		if (clean || $urandom_range(0, 2) != 0) begin
			lat = good_coord();
			lon = good_coord();
		end else begin
			lat = ($urandom_range(0, 1) != 0) ? bad_coord() : good_coord();
			lon = ($urandom_range(0, 1) != 0) ? bad_coord() : good_coord();
		end
		if (!clean) begin
			case ($urandom_range(0, 7))
				0: pre = {junk_char(), junk_char()};
				1: pre = "$GP";
				2: pre = ",";
				default: pre = "";
			endcase
		end
		if ($urandom_range(0, 4) == 0)
			tail = "";
		else
			tail = ",1,08,0.9,545.4,M,46.9,M,,*47";
		if ($urandom_range(0, 1) != 0)
			eol = "\r\n";
		else
			eol = "\n";
		return {pre, "$GPGGA,", digits(6), ".00,", lat, ",", hemi_text(clean), ",",
			lon, ",", hemi_text(clean), tail, eol};
	endfunction

	task automatic send_noise_line();
		int n;
		n = $urandom_range(1, 40);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
		send_byte(CHAR_LF);
	endtask

	// wrong header, header split by a newline, or a sentence cut short
	task automatic send_framing_oddity();
		string s;
		string hdr;
		int k;
		case ($urandom_range(0, 2))
			0: begin
				s = gga_line(1'b1);
				if ($urandom_range(0, 1) != 0)
					hdr = "$GPRMC";
				else
					hdr = "$GNGGA";
				s = {hdr, s.substr(6, s.len() - 1)};
			end
			1: begin
				s = gga_line(1'b1);
				k = $urandom_range(1, 5);
				s = {s.substr(0, k - 1), "\n", s.substr(k, s.len() - 1)};
			end
			default: begin
				s = gga_line(1'b1);
				k = $urandom_range(1, s.len() - 2);
				s = {s.substr(0, k - 1), "\n"};
			end
		endcase
		send_text(s);
	endtask

	// typical sentences, both hemisphere letters, the open last field
	task automatic test_reference_lines();
		send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
		send_text("$GPGGA,123519,4807.038,S,01131.000,W,1,08,0.9,545.4,M,46.9,M,,*47\n");
		send_text("$GPGGA,0,3345.12345,W,15112.5,S,1\n");
		send_text("$GPGGA,0,4807.038,N,01131.000,W\n");
		send_text("$GPGGA,0,4807.038,N,01131.000,W\r\n");
	endtask

	// largest and smallest values, fraction truncation and padding
	task automatic test_extremes();
		send_text("$GPGGA,0,99999.99999,S,99999.9999999,W,1\n");
		send_text("$GPGGA,0,00.0,N,00,E,1\n");
		send_text("$GPGGA,0,9959.,N,17959.9999999999,E,1\n");
	endtask

	// empty and malformed coordinates, odd hemisphere fields
	task automatic test_malformed();
		send_text("$GPGGA,0,,S,,W,1\n");
		send_text("$GPGGA,0,5.5,N,12345.6,E\n");
		send_text("$GPGGA,0,123456.7,N,0113.0,E\n");
		send_text("$GPGGA,0,48.07.0,N,01131..0,E\n");
		send_text("$GPGGA,0,48A7.0,N,-0113.0,E\n");
		send_text("$GPGGA,0,.5,N,0113.,E\n");
		send_text("$GPGGA,0,4807.0,SS,01131.0,s\n");
	endtask

	// header placement, comma counting and line framing
	task automatic test_framing();
		send_text("$GPGGA,0,4807.0,S,01131.0\n");
		send_text("$GPRMC,0,4807.0,S,01131.0,W,1\n");
		send_text("xx,$GPGGA,4807.0,S,01131.0,W,1\n");
		send_text("a,b,4807.0,N,01131.0,E,$GPGGA\n");
		send_text("$GPG\nGA,0,4807.0,S,01131.0,W,1\n");
		send_text("$$GPGGA,0,1234.5,N,1234.5,E\n");
		send_text("$GPGG$GPGGA,0,1234.5,W,1234.5,S\n");
		send_text("$GPGGA,0,4807.0,S,01131.0,W,,,,,,,,,,\n");
		send_text("\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_text("$GPGGA,0,0100.5,N,0100.5,E,1\n");
	endtask

	// bulk traffic: mostly sentences with random content, some noise
	task automatic test_random_traffic();
		int r;
		int stop;
		stop = byte_cnt + 200;
		while (byte_cnt < stop) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				send_text(gga_line(1'b1));
			else if (r < 85)
				send_text(gga_line(1'b0));
			else if (r < 93)
				send_noise_line();
			else
				send_framing_oddity();
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
	endtask

	// sender holds off until every position is out, then resumes
	task automatic test_drain_pause();
		send_text(gga_line(1'b1));
		wait_drained();
		send_text(gga_line(1'b0));
		send_text(gga_line(1'b1));
		wait_drained();
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (4) send_text(gga_line(1'b1));
		repeat (2) send_text(gga_line(1'b0));
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reference_lines();
		test_extremes();
		test_malformed();
		test_framing();
		test_drain_pause();
		test_random_traffic();
		test_back_to_back();
		wait_drained();
		repeat (20) @(negedge clk);

		$display("sent %0d bytes of nmea text, checked %0d positions, %0d mismatches",
			byte_cnt, fix_seen, err_cnt);
		if (err_cnt == 0 && fix_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
